/* rtl/core/nkp_pkg.sv */
// Package with the request types, parse codes and hash helpers of the name key parser.
package nkp_pkg;

  localparam int unsigned KeyW = 64;

  localparam logic [KeyW-1:0] HashPoly  = 64'h2B59_2653_5897_936A;
  localparam logic [KeyW-1:0] AllOnes   = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [KeyW-1:0] SeedReset = AllOnes;

  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChLowerX  = 8'h78;
  localparam logic [7:0] ChUpperX  = 8'h58;
  localparam logic [7:0] ChDot     = 8'h2E;
  localparam logic [7:0] FoldAdd   = 8'hBF;
  localparam logic [7:0] FoldSpan  = 8'h19;
  localparam logic [7:0] FoldShift = 8'h20;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       is_last;
  } nkp_in_t;

  typedef struct packed {
    logic [KeyW-1:0] name_key;
    logic [KeyW-1:0] type_key;
    logic [1:0]      key_form;
  } nkp_out_t;

  typedef enum logic [3:0] {
    PH_DECIDE = 4'b0001,
    PH_PLAIN  = 4'b0010,
    PH_HEX    = 4'b0100,
    PH_TAIL   = 4'b1000
  } nkp_phase_e;

  typedef enum logic [4:0] {
    TH_ZERO   = 5'b00001,
    TH_X      = 5'b00010,
    TH_FIRST  = 5'b00100,
    TH_DIGITS = 5'b01000,
    TH_FAIL   = 5'b10000
  } nkp_tail_e;

  localparam logic [1:0] FormPlain    = 2'd0;
  localparam logic [1:0] FormHex      = 2'd1;
  localparam logic [1:0] FormTypeHash = 2'd2;
  localparam logic [1:0] FormTypeHex  = 2'd3;

  // Carry-less product of the index and the polynomial, kept to 64 bits.
  function automatic logic [KeyW-1:0] crc_table(input logic [7:0] idx);
    logic [KeyW-1:0] r;
    r = '0;
    for (int b = 0; b < 8; b++) begin
      if (idx[b]) begin
        r = r ^ (HashPoly << b);
      end
    end
    return r;
  endfunction

  // Returns the digit value in the low nibble and a valid flag on top.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  // Shifts in one hex digit and saturates to all ones on overflow.
  function automatic logic [KeyW-1:0] hex_push(input logic [KeyW-1:0] v,
                                               input logic [3:0]      d);
    logic [KeyW-1:0] r;
    if (v[KeyW-1 -: 4] != 4'd0) begin
      r = AllOnes;
    end else begin
      r = {v[KeyW-5:0], d};
    end
    return r;
  endfunction

endpackage

/* rtl/core/nkp_hash_unit.sv */
// One byte step of the table hash, with case folding and sign extension.
module nkp_hash_unit (
  input  logic [nkp_pkg::KeyW-1:0] hash_i,
  input  logic [7:0]               char_i,
  output logic [nkp_pkg::KeyW-1:0] hash_o
);
  import nkp_pkg::*;

  logic [7:0]      folded;
  logic [7:0]      shifted;
  logic [KeyW-1:0] extended;

  always_comb begin
    shifted  = char_i + FoldAdd;
    folded   = (shifted <= FoldSpan) ? char_i + FoldShift : char_i;
    extended = {{(KeyW-8){folded[7]}}, folded};
    hash_o   = extended ^ crc_table(hash_i[KeyW-1 -: 8]) ^ (hash_i << 8);
  end

endmodule

/* rtl/core/nkp_core.sv */
// Per-name parse state and the combinational step that yields the key result.
module nkp_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [nkp_pkg::KeyW-1:0] seed_i,
  input  logic                     step_i,
  input  nkp_pkg::nkp_in_t         item_i,
  output nkp_pkg::nkp_out_t        result_o
);
  import nkp_pkg::*;

  localparam logic [1:0] PosSat = 2'd2;

  logic [1:0]      pos_q, pos_d, pos_n;
  nkp_phase_e      phase_q, phase_d, phase_n;
  logic [KeyW-1:0] whole_q, whole_d, whole_n;
  logic [KeyW-1:0] tail_hash_q, tail_hash_d, tail_hash_n;
  logic [KeyW-1:0] prefix_q, prefix_d, prefix_n;
  logic            stopped_q, stopped_d, stopped_n;
  logic [KeyW-1:0] tail_val_q, tail_val_d, tail_val_n;
  nkp_tail_e       tail_ph_q, tail_ph_d, tail_ph_n;

  logic [7:0]      c;
  logic [4:0]      dig;
  logic            is_x;
  logic [KeyW-1:0] whole_base;
  logic [KeyW-1:0] whole_step;
  logic [KeyW-1:0] tail_step;

  assign c          = item_i.char_byte;
  assign dig        = hex_digit(c);
  assign is_x       = (c == ChLowerX) || (c == ChUpperX);
  assign whole_base = (pos_q == 2'd0) ? seed_i : whole_q;

  nkp_hash_unit u_whole_hash (
    .hash_i (whole_base),
    .char_i (c),
    .hash_o (whole_step)
  );

  nkp_hash_unit u_tail_hash (
    .hash_i (tail_hash_q),
    .char_i (c),
    .hash_o (tail_step)
  );

  always_comb begin
    pos_n       = (pos_q == PosSat) ? pos_q : pos_q + 2'd1;
    whole_n     = whole_step;
    phase_n     = phase_q;
    tail_hash_n = tail_hash_q;
    prefix_n    = prefix_q;
    stopped_n   = stopped_q;
    tail_val_n  = tail_val_q;
    tail_ph_n   = tail_ph_q;

    case (phase_q)
      PH_DECIDE: begin
        if (pos_q == 2'd0) begin
          if (c != ChZero) begin
            phase_n = PH_PLAIN;
          end
        end else begin
          phase_n = is_x ? PH_HEX : PH_PLAIN;
        end
      end
      PH_HEX: begin
        if (c == ChDot) begin
          phase_n     = PH_TAIL;
          tail_hash_n = seed_i;
          tail_val_n  = '0;
          tail_ph_n   = TH_ZERO;
        end else if (!stopped_q) begin
          if (dig[4]) begin
            prefix_n = hex_push(prefix_q, dig[3:0]);
          end else begin
            stopped_n = 1'b1;
          end
        end
      end
      PH_TAIL: begin
        tail_hash_n = tail_step;
        case (tail_ph_q)
          TH_ZERO: tail_ph_n = (c == ChZero) ? TH_X : TH_FAIL;
          TH_X:    tail_ph_n = is_x ? TH_FIRST : TH_FAIL;
          TH_FIRST, TH_DIGITS: begin
            if (dig[4]) begin
              tail_val_n = hex_push(tail_val_q, dig[3:0]);
              tail_ph_n  = TH_DIGITS;
            end else begin
              tail_ph_n = TH_FAIL;
            end
          end
          default: tail_ph_n = TH_FAIL;
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    case (phase_n)
      PH_HEX: begin
        result_o.name_key = prefix_n;
        result_o.type_key = '0;
        result_o.key_form = FormHex;
      end
      PH_TAIL: begin
        result_o.type_key = prefix_n;
        if (tail_ph_n == TH_DIGITS) begin
          result_o.name_key = tail_val_n;
          result_o.key_form = FormTypeHex;
        end else begin
          result_o.name_key = tail_hash_n;
          result_o.key_form = FormTypeHash;
        end
      end
      default: begin
        result_o.name_key = whole_n;
        result_o.type_key = '0;
        result_o.key_form = FormPlain;
      end
    endcase
  end

  // The last byte of a name returns every per-name register to its start value.
  always_comb begin
    if (item_i.is_last) begin
      pos_d       = 2'd0;
      phase_d     = PH_DECIDE;
      whole_d     = seed_i;
      tail_hash_d = seed_i;
      prefix_d    = '0;
      stopped_d   = 1'b0;
      tail_val_d  = '0;
      tail_ph_d   = TH_ZERO;
    end else begin
      pos_d       = pos_n;
      phase_d     = phase_n;
      whole_d     = whole_n;
      tail_hash_d = tail_hash_n;
      prefix_d    = prefix_n;
      stopped_d   = stopped_n;
      tail_val_d  = tail_val_n;
      tail_ph_d   = tail_ph_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= 2'd0;
      phase_q     <= PH_DECIDE;
      whole_q     <= SeedReset;
      tail_hash_q <= SeedReset;
      prefix_q    <= '0;
      stopped_q   <= 1'b0;
      tail_val_q  <= '0;
      tail_ph_q   <= TH_ZERO;
    end else if (step_i) begin
      pos_q       <= pos_d;
      phase_q     <= phase_d;
      whole_q     <= whole_d;
      tail_hash_q <= tail_hash_d;
      prefix_q    <= prefix_d;
      stopped_q   <= stopped_d;
      tail_val_q  <= tail_val_d;
      tail_ph_q   <= tail_ph_d;
    end
  end

endmodule

/* rtl/core/name_key_parser_crc64_hash.sv */
// Top level of the name key parser: input register, parse core, result register, seed.
//
//   channel | handshake              | payload
//   --------+------------------------+------------------------------------------
//   in      | in_valid_i / in_stall_o | in_data_i  (char_byte, is_last)
//   out     | out_valid_o/out_stall_i | out_data_o (name_key, type_key, key_form)
//   cfg     | cfg_valid_i/cfg_ready_o | cfg_data_i (hash_seed)
//
// One byte per cycle while nothing stalls: a request is held in the input
// register, and the parse core with its two table hash steps finishes it there.
// The key of a name is loaded into the result register at the edge where its
// last byte leaves the input register.
// Reset sets the seed to all ones and clears the parse state.
// A stalled result holds only bytes that end a name; other bytes keep flowing.
module name_key_parser_crc64_hash (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  nkp_pkg::nkp_in_t         in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output nkp_pkg::nkp_out_t        out_data_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [nkp_pkg::KeyW-1:0] cfg_data_i
);
  import nkp_pkg::*;

  logic            s1_valid_q, s1_valid_d;
  nkp_in_t         s1_item_q;
  logic            s1_go;
  logic            in_accept;
  logic            out_valid_q, out_valid_d;
  nkp_out_t        out_q;
  nkp_out_t        core_result;
  logic [KeyW-1:0] seed_q;

  // The held byte moves on unless it ends a name and the result register is full and stalled.
  assign s1_go       = s1_valid_q &&
                       (!s1_item_q.is_last || !out_valid_q || !out_stall_i);
  assign in_stall_o  = s1_valid_q && !s1_go;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_go) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
    if (s1_go && s1_item_q.is_last) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  nkp_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .seed_i   (seed_q),
    .step_i   (s1_go),
    .item_i   (s1_item_q),
    .result_o (core_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      seed_q      <= SeedReset;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        seed_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_item_q <= in_data_i;
    end
    if (s1_go && s1_item_q.is_last) begin
      out_q <= core_result;
    end
  end

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && s1_item_q.is_last && out_valid_q))
    else $error("input stalled without a pending name end");

  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_go && s1_item_q.is_last) |=> out_valid_o)
    else $error("name end did not produce a result");

  a_no_type_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.key_form == FormPlain || out_data_o.key_form == FormHex))
      |-> (out_data_o.type_key == '0))
    else $error("type key set on a result without a type");

endmodule

/* sim/tb_name_key_parser_crc64_hash.sv */
// Testbench for the name key parser: directed and random names checked against a predictor.
module tb_name_key_parser_crc64_hash;
  import nkp_pkg::*;

  class name_key_tracker;
    logic [KeyW-1:0] seed;
    int unsigned     position;
    nkp_phase_e      phase;
    logic [KeyW-1:0] whole_hash;
    logic [KeyW-1:0] tail_hash;
    logic [KeyW-1:0] type_value;
    bit              type_stopped;
    logic [KeyW-1:0] tail_value;
    nkp_tail_e       tail_state;
    nkp_out_t        keys_due[$];
    int unsigned     mismatches;

    function new();
      seed = SeedReset;
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      position = 0;
      phase = PH_DECIDE;
      whole_hash = seed;
      tail_hash = seed;
      type_value = '0;
      type_stopped = 1'b0;
      tail_value = '0;
      tail_state = TH_ZERO;
    endfunction

    function void set_seed(logic [KeyW-1:0] value);
      seed = value;
    endfunction

    function int unsigned pending();
      return keys_due.size();
    endfunction

    // Table row is built MSB first as a shift-and-xor of the polynomial.
    function logic [KeyW-1:0] mix_byte(logic [KeyW-1:0] h, logic [7:0] c);
      logic [KeyW-1:0] row;
      logic [7:0]      top;
      row = '0;
      top = h[KeyW-1 -: 8];
      if (c >= "A" && c <= "Z") begin
        c = c + FoldShift;
      end
      for (int b = 7; b >= 0; b--) begin
        row = (row << 1) ^ (top[b] ? HashPoly : '0);
      end
      return {{56{c[7]}}, c} ^ row ^ (h << 8);
    endfunction

    function int hex_value(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - 8'h30);
      if (c >= "a" && c <= "f") return int'(c - 8'h57);
      if (c >= "A" && c <= "F") return int'(c - 8'h37);
      return -1;
    endfunction

    function logic [KeyW-1:0] append_digit(logic [KeyW-1:0] v, int d);
      if (v > 64'h0FFF_FFFF_FFFF_FFFF) return AllOnes;
      return {v[KeyW-5:0], 4'(d)};
    endfunction

    function void take_byte(nkp_in_t req);
      logic [7:0] c;
      int         d;
      nkp_out_t   key;
      c = req.char_byte;
      d = hex_value(c);
      whole_hash = mix_byte(position == 0 ? seed : whole_hash, c);
      case (phase)
        PH_DECIDE: begin
          if (position == 0) begin
            if (c != ChZero) phase = PH_PLAIN;
          end else begin
            phase = (c == ChLowerX || c == ChUpperX) ? PH_HEX : PH_PLAIN;
          end
        end
        PH_HEX: begin
          if (c == ChDot) begin
            phase = PH_TAIL;
            tail_hash = seed;
            tail_value = '0;
            tail_state = TH_ZERO;
          end else if (!type_stopped) begin
            if (d >= 0) type_value = append_digit(type_value, d);
            else type_stopped = 1'b1;
          end
        end
        PH_TAIL: begin
          tail_hash = mix_byte(tail_hash, c);
          case (tail_state)
            TH_ZERO: tail_state = (c == ChZero) ? TH_X : TH_FAIL;
            TH_X: tail_state = (c == ChLowerX || c == ChUpperX) ? TH_FIRST : TH_FAIL;
            TH_FIRST, TH_DIGITS: begin
              if (d >= 0) begin
                tail_value = append_digit(tail_value, d);
                tail_state = TH_DIGITS;
              end else begin
                tail_state = TH_FAIL;
              end
            end
            default: tail_state = TH_FAIL;
          endcase
        end
        default: ;
      endcase
      if (position < 2) position++;
      if (!req.is_last) return;

      key.type_key = '0;
      if (phase == PH_HEX) begin
        key.name_key = type_value;
        key.key_form = FormHex;
      end else if (phase == PH_TAIL) begin
        key.type_key = type_value;
        if (tail_state == TH_DIGITS) begin
          key.name_key = tail_value;
          key.key_form = FormTypeHex;
        end else begin
          key.name_key = tail_hash;
          key.key_form = FormTypeHash;
        end
      end else begin
        key.name_key = whole_hash;
        key.key_form = FormPlain;
      end
      keys_due = {keys_due, key};
      restart();
    endfunction

    function void flag(string what, logic [KeyW-1:0] want, logic [KeyW-1:0] got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch in %s: expected %h, got %h", what, want, got);
      end
    endfunction

    function void check_key(nkp_out_t got);
      nkp_out_t want;
      if (keys_due.size() == 0) begin
        flag("key with no name pending", '0, got.name_key);
        return;
      end
      want = keys_due.pop_front();
      if (got.name_key !== want.name_key) flag("name_key", want.name_key, got.name_key);
      if (got.type_key !== want.type_key) flag("type_key", want.type_key, got.type_key);
      if (got.key_form !== want.key_form) begin
        flag("key_form", 64'(want.key_form), 64'(got.key_form));
      end
    endfunction
  endclass

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid_i = 1'b0;
  logic            in_stall_o;
  nkp_in_t         in_data_i = '0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  nkp_out_t        out_data_o;
  logic            cfg_valid_i = 1'b0;
  logic            cfg_ready_o;
  logic [KeyW-1:0] cfg_data_i = '0;
  bit              quiet = 1'b0;
  name_key_tracker keys;

  name_key_parser_crc64_hash dut (.*);

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) keys.check_key(out_data_o);
      if (in_valid_i && !in_stall_o) keys.take_byte(in_data_i);
      if (cfg_valid_i && cfg_ready_o) keys.set_seed(cfg_data_i);
    end
  end

  task automatic send_byte(input logic [7:0] c, input logic last);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{char_byte: c, is_last: last};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i], i == s.len() - 1);
    end
  endtask

  task automatic write_seed(input logic [KeyW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    int unsigned waited;
    waited = 0;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (keys.pending() != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [7:0] hex_char();
    case ($urandom_range(0, 2))
      0: return 8'(8'h30 + $urandom_range(0, 9));
      1: return 8'(8'h61 + $urandom_range(0, 5));
      default: return 8'(8'h41 + $urandom_range(0, 5));
    endcase
  endfunction

  function automatic logic [7:0] any_char();
    case ($urandom_range(0, 5))
      0: return hex_char();
      1: return ChDot;
      2: return 8'(8'h41 + $urandom_range(0, 25));
      3: return $urandom_range(0, 1) ? ChLowerX : ChUpperX;
      default: return 8'($urandom);
    endcase
  endfunction

  // Long runs of digits push the hex reader into saturation.
  function automatic int unsigned digit_count();
    return ($urandom_range(0, 5) == 0) ? $urandom_range(15, 18) : $urandom_range(0, 8);
  endfunction

  task automatic send_random_name(output int unsigned length);
    logic [7:0]  text[$];
    int unsigned kind;
    kind = $urandom_range(0, 9);
    quiet = ($urandom_range(0, 5) == 0);
    if (kind < 2) begin
      repeat ($urandom_range(1, 12)) text = {text, any_char()};
    end else if (kind == 9) begin
      repeat ($urandom_range(1, 6)) text = {text, 8'($urandom)};
    end else begin
      text = {text, ChZero};
      text = {text, $urandom_range(0, 1) ? ChLowerX : ChUpperX};
      repeat (digit_count()) text = {text, hex_char()};
      if (kind >= 4) begin
        text = {text, ChDot};
        if (kind <= 6) begin
          text = {text, ChZero};
          text = {text, $urandom_range(0, 1) ? ChLowerX : ChUpperX};
          repeat (digit_count()) text = {text, hex_char()};
        end else begin
          repeat ($urandom_range(0, 8)) text = {text, any_char()};
        end
      end
      // Trailing junk breaks an otherwise well-formed name now and then.
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 4)) text = {text, any_char()};
      end
    end
    length = text.size();
    foreach (text[i]) send_byte(text[i], i == text.size() - 1);
  endtask

  initial begin
    int unsigned sent;
    int unsigned length;
    logic [KeyW-1:0] seed_value;
    keys = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_text("A");
    send_byte(8'hFF, 1'b1);
    send_text("0x");
    send_text("0X.");
    send_text("0xa.0xB");
    send_text("0x-");
    send_byte(ChZero, 1'b0);
    send_byte(8'h00, 1'b1);
    send_text("0x.0x");

    for (int p = 0; p < 6; p++) begin
      wait_drained();
      case (p)
        0: seed_value = '0;
        1: seed_value = {$urandom, $urandom};
        2: seed_value = AllOnes;
        3: seed_value = 64'h8000_0000_0000_0000;
        4: seed_value = 64'h0000_0000_0000_0001;
        default: seed_value = {$urandom, $urandom};
      endcase
      write_seed(seed_value);
      sent = 0;
      while (sent < 233) begin
        send_random_name(length);
        sent += length;
      end
    end
    quiet = 1'b0;
    wait_drained();

    if (keys.mismatches == 0 && keys.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    int unsigned hold;
    @(posedge rst_ni);
    forever begin
      hold = quiet ? 0 : $urandom_range(0, 17);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  initial begin
    #1_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
